// ----- src/rpcr_pkg.sv -----
// Shared types and constants for the RAID parity check and recovery core.
package rpcr_pkg;

  localparam int MaxDisks     = 8;
  localparam int DiskW        = 3;
  localparam int MaxBlockBits = 64;
  localparam int MaxBlocks    = 1023;
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = 2;
  localparam int AddrW        = 4;
  localparam int DataW        = 32;

  typedef enum logic [1:0] {
    RegDiskCount  = 2'd0,
    RegBlockBits  = 2'd1,
    RegBlockCount = 2'd2,
    RegEvenParity = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] column_bits;
    logic [7:0] column_unknown;
  } col_t;

  typedef struct packed {
    logic [63:0] data_segment;
    logic [2:0]  segment_disk;
    logic        last_of_block;
    logic        last_of_set;
    logic        set_invalid;
  } seg_t;

  typedef struct packed {
    logic [3:0] disk_count;
    logic [6:0] block_bits;
    logic [9:0] block_count;
    logic       parity_even;
  } cfg_t;

  // One classified column handed from the front end to the back end.
  typedef struct packed {
    logic [MaxDisks-1:0] column;
    logic                first;
    logic                block_end;
    logic                set_end;
    logic                invalid;
    logic [DiskW-1:0]    parity_disk;
    logic [3:0]          disks;
    logic [6:0]          block_bits;
  } entry_t;

endpackage

// ----- src/rpcr_regs.sv -----
// Configuration register file behind the APB-style port.
module rpcr_regs import rpcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disk_count  <= 4'd3;
      cfg.block_bits  <= 7'd8;
      cfg.block_count <= 10'd1;
      cfg.parity_even <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegDiskCount:  cfg.disk_count  <= pwdata[3:0];
        RegBlockBits:  cfg.block_bits  <= pwdata[6:0];
        RegBlockCount: cfg.block_count <= pwdata[9:0];
        RegEvenParity: cfg.parity_even <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegDiskCount:  prdata = {28'd0, cfg.disk_count};
      RegBlockBits:  prdata = {25'd0, cfg.block_bits};
      RegBlockCount: prdata = {22'd0, cfg.block_count};
      RegEvenParity: prdata = {31'd0, cfg.parity_even};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- src/rpcr_front.sv -----
// Front end: accepts columns, checks parity, repairs one unknown bit, tracks position.
module rpcr_front import rpcr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   col_valid,
  output logic   col_stall,
  input  col_t   col,
  input  cfg_t   cfg,
  input  logic   full,
  output logic   push,
  output entry_t entry
);

  logic [5:0]          bit_position;
  logic [9:0]          block_index;
  logic [DiskW-1:0]    parity_disk;
  logic                set_failed;

  logic [3:0]          disks;
  logic [6:0]          bb;
  logic [9:0]          bc;
  logic [DiskW-1:0]    pd;
  logic [MaxDisks-1:0] vm;
  logic [MaxDisks-1:0] unkm;
  logic [MaxDisks-1:0] known;
  logic                par;
  logic                want;
  logic                multi;
  logic                fail;
  logic                block_end;
  logic                set_end;
  logic                accept;

  always_comb begin
    if (cfg.disk_count < 4'd2) begin
      disks = 4'd2;
    end else if (cfg.disk_count > 4'(MaxDisks)) begin
      disks = 4'(MaxDisks);
    end else begin
      disks = cfg.disk_count;
    end
    if (cfg.block_bits == 7'd0) begin
      bb = 7'd1;
    end else if (cfg.block_bits > 7'(MaxBlockBits)) begin
      bb = 7'(MaxBlockBits);
    end else begin
      bb = cfg.block_bits;
    end
    if (cfg.block_count == 10'd0) begin
      bc = 10'd1;
    end else if (cfg.block_count > 10'(MaxBlocks)) begin
      bc = 10'(MaxBlocks);
    end else begin
      bc = cfg.block_count;
    end
    for (int k = 0; k < MaxDisks; k++) begin
      vm[k] = 4'(k) < disks;
    end
  end

  assign pd        = ({1'b0, parity_disk} < disks) ? parity_disk : '0;
  assign block_end = ({1'b0, bit_position} + 7'd1) >= bb;
  assign set_end   = block_end && (({1'b0, block_index} + 11'd1) >= {1'b0, bc});

  assign unkm  = col.column_unknown & vm;
  assign known = col.column_bits & ~col.column_unknown & vm;
  assign par   = ^known;
  assign want  = ~cfg.parity_even;
  assign multi = (unkm & (unkm - 8'd1)) != 8'd0;
  assign fail  = ((unkm == 8'd0) && (par != want)) || multi;

  assign col_stall = full;
  assign accept    = col_valid && !full;
  assign push      = accept && !set_failed;

  always_comb begin
    entry.column      = (col.column_bits & ~col.column_unknown) | ((par ^ want) ? unkm : '0);
    entry.first       = bit_position == 6'd0;
    entry.block_end   = block_end;
    entry.set_end     = set_end;
    entry.invalid     = fail;
    entry.parity_disk = pd;
    entry.disks       = disks;
    entry.block_bits  = bb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
      block_index  <= '0;
      parity_disk  <= '0;
      set_failed   <= 1'b0;
    end else if (accept) begin
      set_failed <= set_end ? 1'b0 : (set_failed || fail);
      if (block_end) begin
        bit_position <= '0;
        if (set_end) begin
          block_index <= '0;
          parity_disk <= '0;
        end else begin
          block_index <= block_index + 10'd1;
          parity_disk <= ({1'b0, pd} + 4'd1 >= disks) ? '0 : pd + 3'd1;
        end
      end else begin
        bit_position <= bit_position + 6'd1;
      end
    end
  end

endmodule

// ----- src/rpcr_queue.sv -----
// Short queue of classified columns between front and back ends.
module rpcr_queue import rpcr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   full,
  input  logic   pop,
  output entry_t dout,
  output logic   nonempty
);

  entry_t           mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   level;

  assign full     = level == (QPtrW+1)'(QueueDepth);
  assign nonempty = level != '0;
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (push && !pop) begin
        level <= level + (QPtrW+1)'(1);
      end else if (pop && !push) begin
        level <= level - (QPtrW+1)'(1);
      end
    end
  end

endmodule

// ----- src/rpcr_back.sv -----
// Back end: builds block buffers and emits segments or the invalid result.
module rpcr_back import rpcr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t head,
  input  logic   head_valid,
  output logic   pop,
  output logic   seg_valid,
  input  logic   seg_stall,
  output seg_t   seg
);

  logic [MaxBlockBits-1:0] buffer [MaxDisks];
  logic [MaxBlockBits-1:0] bank   [MaxDisks];
  logic [MaxBlockBits-1:0] upd    [MaxDisks];

  logic                    job_active;
  logic                    job_inv;
  logic                    job_set_end;
  logic [MaxDisks-1:0]     job_rem;
  logic [MaxBlockBits-1:0] job_mask;

  logic [MaxDisks-1:0]     vm;
  logic [DiskW-1:0]        sel;
  logic [MaxDisks-1:0]     rem_after;
  logic                    job_last;
  logic                    emit_ok;
  logic                    job_free;
  logic                    needs_job;

  always_comb begin
    for (int k = 0; k < MaxDisks; k++) begin
      vm[k] = 4'(k) < head.disks;
      if (vm[k]) begin
        upd[k] = head.first ? {{(MaxBlockBits-1){1'b0}}, head.column[k]}
                            : {buffer[k][MaxBlockBits-2:0], head.column[k]};
      end else begin
        upd[k] = buffer[k];
      end
    end
    sel = '0;
    for (int k = MaxDisks - 1; k >= 0; k--) begin
      if (job_rem[k]) begin
        sel = DiskW'(k);
      end
    end
  end

  assign rem_after = job_rem & ~(8'd1 << sel);
  assign job_last  = job_inv || (rem_after == '0);
  assign emit_ok   = job_active && (!seg_valid || !seg_stall);
  assign job_free  = !job_active || (emit_ok && job_last);
  assign needs_job = head.block_end || head.invalid;
  assign pop       = head_valid && (!needs_job || job_free);

  always_ff @(posedge clk) begin
    if (pop && !head.invalid) begin
      for (int k = 0; k < MaxDisks; k++) begin
        buffer[k] <= upd[k];
      end
    end
    if (pop && needs_job) begin
      job_inv     <= head.invalid;
      job_set_end <= head.set_end;
      job_rem     <= vm & ~(8'd1 << head.parity_disk);
      job_mask    <= {MaxBlockBits{1'b1}} >> (7'(MaxBlockBits) - head.block_bits);
      if (!head.invalid) begin
        for (int k = 0; k < MaxDisks; k++) begin
          bank[k] <= upd[k];
        end
      end
    end else if (emit_ok) begin
      job_rem <= rem_after;
    end
    if (emit_ok) begin
      if (job_inv) begin
        seg <= '{data_segment: '0, segment_disk: '0, last_of_block: 1'b0,
                 last_of_set: 1'b1, set_invalid: 1'b1};
      end else begin
        seg <= '{data_segment: bank[sel] & job_mask, segment_disk: sel,
                 last_of_block: job_last, last_of_set: job_last && job_set_end,
                 set_invalid: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_active <= 1'b0;
      seg_valid  <= 1'b0;
    end else begin
      if (pop && needs_job) begin
        job_active <= 1'b1;
      end else if (emit_ok && job_last) begin
        job_active <= 1'b0;
      end
      if (emit_ok) begin
        seg_valid <= 1'b1;
      end else if (!seg_stall) begin
        seg_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/raid_parity_check_recover_core.sv -----
// Top level: RAID parity check and single-erasure recovery core.
// Throughput: one column per cycle while the 4-entry queue has room; the segment
// emitter sends one segment per cycle while seg_stall does not hold the output.
// Reset (rst, synchronous): registers to defaults, counters, queue, emitter and output
// valid cleared; block buffers are not cleared.
module raid_parity_check_recover_core import rpcr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             col_valid,
  output logic             col_stall,
  input  col_t             col,
  output logic             seg_valid,
  input  logic             seg_stall,
  output seg_t             seg,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t   cfg;
  logic   push;
  logic   full;
  logic   pop;
  logic   nonempty;
  entry_t entry_in;
  entry_t entry_out;

  rpcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .col_valid (col_valid),
    .col_stall (col_stall),
    .col       (col),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .entry     (entry_in)
  );

  rpcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (entry_in),
    .full     (full),
    .pop      (pop),
    .dout     (entry_out),
    .nonempty (nonempty)
  );

  rpcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (entry_out),
    .head_valid (nonempty),
    .pop        (pop),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg        (seg)
  );

  a_invalid_shape: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.set_invalid |->
      seg.last_of_set && !seg.last_of_block && seg.data_segment == 64'd0)
    else $error("invalid result carries segment data");

  a_set_ends_block: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.last_of_set && !seg.set_invalid |-> seg.last_of_block)
    else $error("set ended in mid block");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !seg_valid)
    else $error("output valid after reset");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("queue read while empty");

endmodule
